// ----- src/pknm_pkg.sv -----
// shared types and constants for the packed k-mer near-match unit
`default_nettype none

package pknm_pkg;

	localparam int LOW_BASES = 32;
	localparam int LOW_W     = 2 * LOW_BASES;
	localparam int IDX_W     = 6;
	localparam int DIST_W    = 6;
	localparam int MAXD_W    = 6;

	localparam logic [MAXD_W-1:0] MAXD_RESET = 6'd10;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} pknm_state_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic emit_done;
	} pknm_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pipe_empty;
		logic adv;
	} pknm_status_t;

endpackage

`default_nettype wire

// ----- src/pknm_if.sv -----
// channel interfaces for probe input and result output
`default_nettype none

interface pknm_probe_if #(
	parameter int HIGH_W = 36
);
	logic                          valid;
	logic                          ready;
	logic [pknm_pkg::LOW_W-1:0]    probe_low;
	logic [HIGH_W-1:0]             probe_high;
	logic                          start_new_set;

	modport source (output valid, output probe_low, output probe_high,
		output start_new_set, input ready);
	modport sink (input valid, input probe_low, input probe_high,
		input start_new_set, output ready);
endinterface

interface pknm_result_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [pknm_pkg::DIST_W-1:0]   distance;
	logic [pknm_pkg::IDX_W-1:0]    earlier_index;
	logic [pknm_pkg::IDX_W-1:0]    probe_index;
	logic                          stored;
	logic                          last;

	modport source (output valid, output kind, output distance, output earlier_index,
		output probe_index, output stored, output last, input ready);
	modport sink (input valid, input kind, input distance, input earlier_index,
		input probe_index, input stored, input last, output ready);
endinterface

`default_nettype wire

// ----- src/pknm_ctrl.sv -----
// controller state machine: accept, scan the store, drain and finish
`default_nettype none

module pknm_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   probe_valid,
	output logic                        probe_ready,
	input  wire pknm_pkg::pknm_status_t status,
	output pknm_pkg::pknm_cmd_t         cmd
);
	import pknm_pkg::*;

	pknm_state_t state_q;
	pknm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (probe_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_done) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.pipe_empty && status.adv) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		probe_ready   = 1'b0;
		cmd.load      = 1'b0;
		cmd.issue     = 1'b0;
		cmd.emit_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				probe_ready = 1'b1;
				cmd.load    = probe_valid;
			end
			ST_SCAN: begin
				// datapath gates the read with the pipeline advance
				cmd.issue = !status.scan_done;
			end
			ST_DRAIN: begin
				cmd.emit_done = status.pipe_empty && status.adv;
			end
			default: begin
				probe_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/pknm_dp.sv -----
// datapath: probe store, distance pipeline, match filter and result register
`default_nettype none

module pknm_dp #(
	parameter int STORE_DEPTH = 64,
	parameter int PROBE_BASES = 50
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          cfg_we,
	input  wire logic [pknm_pkg::MAXD_W-1:0]                   cfg_wdata,
	input  wire logic [pknm_pkg::LOW_W-1:0]                    probe_low,
	input  wire logic [2*(PROBE_BASES-pknm_pkg::LOW_BASES)-1:0] probe_high,
	input  wire logic                                          start_new_set,
	input  wire pknm_pkg::pknm_cmd_t                           cmd,
	output pknm_pkg::pknm_status_t                             status,
	output logic                                               res_valid,
	input  wire logic                                          res_ready,
	output logic                                               res_kind,
	output logic [pknm_pkg::DIST_W-1:0]                        res_distance,
	output logic [pknm_pkg::IDX_W-1:0]                         res_earlier_index,
	output logic [pknm_pkg::IDX_W-1:0]                         res_probe_index,
	output logic                                               res_stored,
	output logic                                               res_last
);
	import pknm_pkg::*;

	localparam int HIGH_W = 2 * (PROBE_BASES - LOW_BASES);
	localparam int KEY_W  = 2 * PROBE_BASES;
	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int CW     = $clog2(STORE_DEPTH + 1);
	localparam int NG     = (PROBE_BASES + 7) / 8;
	localparam int DSW    = $clog2(PROBE_BASES + 1);

	logic [KEY_W-1:0]  mem [STORE_DEPTH];

	logic [KEY_W-1:0]  key_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     issue_q;
	logic [CW-1:0]     emitted_q;
	logic [MAXD_W-1:0] maxd_q;

	logic              v_s1, v_s2, v_s3;
	logic [KEY_W-1:0]  rd_s1;
	logic [AW-1:0]     idx_s1, idx_s2, idx_s3;
	logic [3:0]        grp_s2 [NG];
	logic [DSW-1:0]    dist_s3;

	logic              adv;
	logic              room;
	logic              rd_en;
	logic              hit;
	logic [CW-1:0]     pidx;
	logic [NG*8-1:0]   flags;
	logic [KEY_W-1:0]  diff;
	logic [DSW-1:0]    dist_sum;

	logic [AW+IDX_W-1:0]   earlier_ext;
	logic [CW+IDX_W-1:0]   pidx_ext;
	logic [DSW+DIST_W-1:0] dist_ext;

	assign adv   = !res_valid || res_ready;
	assign room  = count_q < CW'(STORE_DEPTH);
	assign pidx  = room ? count_q : '0;
	assign rd_en = cmd.issue && adv;

	assign status.scan_done  = (issue_q == count_q);
	assign status.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign status.adv        = adv;

	// at most STORE_DEPTH-1 match results are emitted per probe
	assign hit = v_s3 && ({1'b0, dist_s3} <= (DSW+1)'(maxd_q))
		&& (emitted_q < CW'(STORE_DEPTH - 1));

	assign earlier_ext = {{IDX_W{1'b0}}, idx_s3};
	assign pidx_ext    = {{IDX_W{1'b0}}, pidx};
	assign dist_ext    = {{DIST_W{1'b0}}, dist_s3};

	// one flag per mismatching base
	always_comb begin
		diff  = rd_s1 ^ key_q;
		flags = '0;
		for (int b = 0; b < PROBE_BASES; b++) begin
			flags[b] = diff[2*b] | diff[2*b+1];
		end
	end

	always_comb begin
		dist_sum = '0;
		for (int g = 0; g < NG; g++) begin
			dist_sum = dist_sum + DSW'(grp_s2[g]);
		end
	end

	// store memory, one read port for the scan, written once per probe while the store has room
	always_ff @(posedge clk) begin
		if (cmd.emit_done && room) begin
			mem[count_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rd_s1 <= mem[issue_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= {probe_high, probe_low};
		end
		if (rd_en) begin
			idx_s1 <= issue_q[AW-1:0];
		end
		if (adv) begin
			idx_s2  <= idx_s1;
			idx_s3  <= idx_s2;
			dist_s3 <= dist_sum;
			for (int g = 0; g < NG; g++) begin
				grp_s2[g] <= 4'($countones(flags[8*g +: 8]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			issue_q   <= '0;
			emitted_q <= '0;
			maxd_q    <= MAXD_RESET;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			if (cfg_we) maxd_q <= cfg_wdata;
			if (cmd.load) begin
				if (start_new_set) count_q <= '0;
				issue_q   <= '0;
				emitted_q <= '0;
			end else if (cmd.emit_done && room) begin
				count_q <= count_q + CW'(1);
			end
			if (adv) begin
				v_s1 <= rd_en;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				if (rd_en) issue_q <= issue_q + CW'(1);
				if (!cmd.emit_done && hit) emitted_q <= emitted_q + CW'(1);
			end
		end
	end

	// result register, loads only while the sink side lets the pipeline move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= cmd.emit_done || hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cmd.emit_done) begin
				res_kind          <= KIND_DONE;
				res_distance      <= '0;
				res_earlier_index <= '0;
				res_probe_index   <= pidx_ext[IDX_W-1:0];
				res_stored        <= room;
				res_last          <= 1'b1;
			end else begin
				res_kind          <= KIND_MATCH;
				res_distance      <= dist_ext[DIST_W-1:0];
				res_earlier_index <= earlier_ext[IDX_W-1:0];
				res_probe_index   <= pidx_ext[IDX_W-1:0];
				res_stored        <= 1'b0;
				res_last          <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH))
		else $error("stored count beyond store depth");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= CW'(STORE_DEPTH - 1))
		else $error("too many match results for one probe");

	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_done |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("done issued with matches still in flight");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (issue_q < count_q))
		else $error("read issued past the stored entries");
`endif

endmodule

`default_nettype wire

// ----- src/packed_kmer_near_match_unit.sv -----
// top level of the packed k-mer near-match unit
//
//   channel   dir  handshake            payload
//   probe     in   valid/ready          probe_low, probe_high, start_new_set
//   result    out  valid/ready          kind, distance, earlier_index, probe_index,
//                                       stored, last
//   cfg       in   cfg_we (no stall)    cfg_wdata = max_distance
//
// with no stalls on the result side, the single read port of the probe store
// hands out one stored probe per cycle, followed by the distance pipeline
// and the done result.
// the next probe is taken as soon as the done result sits in the output register.
// no clearing pass after reset; store entries are only read below the stored count.
// a stalled result holds the whole scan pipeline in place.
`default_nettype none

module packed_kmer_near_match_unit #(
	parameter int STORE_DEPTH = 64,
	parameter int PROBE_BASES = 50
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pknm_pkg::MAXD_W-1:0]   cfg_wdata,
	pknm_probe_if.sink                         probe,
	pknm_result_if.source                      result
);
	import pknm_pkg::*;

	pknm_cmd_t    cmd;
	pknm_status_t status;

	pknm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.probe_valid (probe.valid),
		.probe_ready (probe.ready),
		.status      (status),
		.cmd         (cmd)
	);

	pknm_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.PROBE_BASES (PROBE_BASES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.probe_low         (probe.probe_low),
		.probe_high        (probe.probe_high),
		.start_new_set     (probe.start_new_set),
		.cmd               (cmd),
		.status            (status),
		.res_valid         (result.valid),
		.res_ready         (result.ready),
		.res_kind          (result.kind),
		.res_distance      (result.distance),
		.res_earlier_index (result.earlier_index),
		.res_probe_index   (result.probe_index),
		.res_stored        (result.stored),
		.res_last          (result.last)
	);

endmodule

`default_nettype wire

// ----- tb/sv/packed_kmer_near_match_unit_tb.sv -----
// self-checking testbench for the packed k-mer near-match unit
`timescale 1ns / 1ps

module packed_kmer_near_match_unit_tb;
	import pknm_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int PROBE_BASES = 50;
	localparam int HIGH_W      = 2 * (PROBE_BASES - LOW_BASES);
	localparam int PROBE_W     = 2 * PROBE_BASES;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 80;
	localparam int NO_CFG      = -1;
	localparam int RAND_MAXD   = -1;

	typedef struct packed {
		logic              kind;
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  earlier_index;
		logic [IDX_W-1:0]  probe_index;
		logic              stored;
		logic              last;
	} near_result_t;

	// typed rows only pin the done item, match items still come from the predictor
	typedef struct packed {
		int               cfg;
		logic [LOW_W-1:0] lo;
		logic [HIGH_W-1:0] hi;
		logic             start;
		logic             typed;
		logic [IDX_W-1:0] t_index;
		logic             t_stored;
	} probe_row_t;

	localparam int N_ROWS = 18;
	localparam probe_row_t PROBE_TABLE [N_ROWS] = '{
		'{NO_CFG, 64'h0, 36'h0, 1'b0, 1'b1, 6'd0, 1'b1},
		'{NO_CFG, 64'hFFFF_FFFF_FFFF_FFFF, 36'hF_FFFF_FFFF, 1'b0, 1'b1, 6'd1, 1'b1},
		'{NO_CFG, 64'h0, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h3, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h1, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h2, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h0, 36'h1, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h0, 36'h8_0000_0000, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'hC000_0000_0000_0000, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h5555_5555_5555_5555, 36'h5_5555_5555, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'hAAAA_AAAA_AAAA_AAAA, 36'hA_AAAA_AAAA, 1'b0, 1'b0, 6'd0, 1'b0},
		'{0, 64'h0, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h1, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{63, 64'h0123_4567_89AB_CDEF, 36'h9_8765_4321, 1'b0, 1'b0, 6'd0, 1'b0},
		'{50, 64'hFFFF_FFFF_FFFF_FFFF, 36'hF_FFFF_FFFF, 1'b0, 1'b0, 6'd0, 1'b0},
		'{10, 64'hFFFF_FFFF_FFFF_FFFF, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0},
		'{NO_CFG, 64'h0, 36'h0, 1'b1, 1'b1, 6'd0, 1'b1},
		'{NO_CFG, 64'h0, 36'h0, 1'b0, 1'b0, 6'd0, 1'b0}
	};

	localparam int N_PHASES = 8;
	localparam int PHASE_MAXD  [N_PHASES] = '{7, 0, 63, 50, 20, 1, 33, RAND_MAXD};
	localparam int PHASE_ITEMS [N_PHASES] = '{50, 50, 72, 50, 50, 40, 40, 38};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MAXD_W-1:0] cfg_wdata;

	pknm_probe_if #(.HIGH_W(HIGH_W)) probe_ch ();
	pknm_result_if result_ch ();

	packed_kmer_near_match_unit #(
		.STORE_DEPTH(STORE_DEPTH),
		.PROBE_BASES(PROBE_BASES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.probe(probe_ch),
		.result(result_ch)
	);

	// predictor state
	logic [LOW_W-1:0]  pred_lo [STORE_DEPTH];
	logic [HIGH_W-1:0] pred_hi [STORE_DEPTH];
	int pred_count;
	int max_dist;
	near_result_t expected_results [$];

	int err_count;
	int idle_cycles;
	bit no_idle;

	// pinned done item of the probe currently offered
	logic cur_typed;
	logic [IDX_W-1:0] cur_t_index;
	logic cur_t_stored;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic predict_near_matches(input logic [LOW_W-1:0] lo,
			input logic [HIGH_W-1:0] hi, input logic start_set);
		logic [PROBE_W-1:0] diff;
		logic room;
		logic [IDX_W-1:0] idx;
		int mism;
		int n;
		near_result_t r;
		if (start_set)
			pred_count = 0;
		room = pred_count < STORE_DEPTH;
		idx = room ? IDX_W'(pred_count) : '0;
		n = 0;
		for (int i = 0; i < pred_count; i++) begin
			diff = {pred_hi[i] ^ hi, pred_lo[i] ^ lo};
			mism = 0;
			for (int b = 0; b < PROBE_BASES; b++)
				if (|diff[2*b +: 2])
					mism++;
			// the scan still runs on a full store but caps the match items
			if (mism <= max_dist && n < STORE_DEPTH - 1) begin
				r = '{KIND_MATCH, DIST_W'(mism), IDX_W'(i), idx, 1'b0, 1'b0};
				expected_results = {expected_results, r};
				n++;
			end
		end
		r = '{KIND_DONE, '0, '0, idx, room, 1'b1};
		expected_results = {expected_results, r};
		if (room) begin
			pred_lo[pred_count] = lo;
			pred_hi[pred_count] = hi;
			pred_count++;
		end
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin
		near_result_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: kind %0d probe_index %0d",
						result_ch.kind, result_ch.probe_index);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, result_ch.kind);
					check_field("distance", want.distance, result_ch.distance);
					check_field("earlier_index", want.earlier_index, result_ch.earlier_index);
					check_field("probe_index", want.probe_index, result_ch.probe_index);
					check_field("stored", want.stored, result_ch.stored);
					check_field("last", want.last, result_ch.last);
				end
			end
			if (probe_ch.valid && probe_ch.ready) begin
				predict_near_matches(probe_ch.probe_low, probe_ch.probe_high,
					probe_ch.start_new_set);
				if (cur_typed) begin
					expected_results[expected_results.size() - 1] =
						'{KIND_DONE, '0, '0, cur_t_index, cur_t_stored, 1'b1};
				end
			end
			if ((result_ch.valid && result_ch.ready) || (probe_ch.valid && probe_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stall before each transfer
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				@(negedge clk) result_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	task automatic send_probe(input logic [LOW_W-1:0] lo, input logic [HIGH_W-1:0] hi,
			input logic start_set, input logic typed, input logic [IDX_W-1:0] t_index,
			input logic t_stored);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk) probe_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		probe_ch.valid         <= 1'b1;
		probe_ch.probe_low     <= lo;
		probe_ch.probe_high    <= hi;
		probe_ch.start_new_set <= start_set;
		cur_typed    <= typed;
		cur_t_index  <= t_index;
		cur_t_stored <= t_stored;
		do @(posedge clk); while (!(probe_ch.valid && probe_ch.ready));
	endtask

	task automatic drain_results();
		@(negedge clk) probe_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_max_distance(input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= MAXD_W'(value);
		max_dist = value;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	initial begin
		logic [PROBE_W-1:0] bases;
		logic [127:0] noise;
		logic st;
		int maxd;
		int kmax;
		int k;
		int j;
		int pos;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		probe_ch.valid = 1'b0;
		probe_ch.probe_low = '0;
		probe_ch.probe_high = '0;
		probe_ch.start_new_set = 1'b0;
		cur_typed = 1'b0;
		cur_t_index = '0;
		cur_t_stored = 1'b0;
		err_count = 0;
		pred_count = 0;
		max_dist = MAXD_RESET;
		no_idle = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (PROBE_TABLE[i]) begin
			if (PROBE_TABLE[i].cfg != NO_CFG) begin
				drain_results();
				write_max_distance(PROBE_TABLE[i].cfg);
			end
			send_probe(PROBE_TABLE[i].lo, PROBE_TABLE[i].hi, PROBE_TABLE[i].start,
				PROBE_TABLE[i].typed, PROBE_TABLE[i].t_index, PROBE_TABLE[i].t_stored);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_results();
			maxd = (PHASE_MAXD[ph] == RAND_MAXD) ? $urandom_range(0, 63) : PHASE_MAXD[ph];
			write_max_distance(maxd);
			no_idle = (ph == 1 || ph == 5);
			kmax = (maxd >= PROBE_BASES) ? PROBE_BASES : maxd + 3;
			for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
				// each phase opens a fresh set; a phase with max distance 63 opens no other and so fills the store
				if (n == 0)
					st = 1'b1;
				else if (maxd == 63)
					st = 1'b0;
				else
					st = ($urandom_range(0, 24) == 0);
				if ($urandom_range(0, 9) < 7 && pred_count > 0) begin
					// near copy of a stored probe so distances cluster round the threshold
					j = $urandom_range(0, pred_count - 1);
					bases = {pred_hi[j], pred_lo[j]};
					k = $urandom_range(0, kmax);
					repeat (k) begin
						pos = $urandom_range(0, PROBE_BASES - 1);
						bases[2*pos +: 2] = 2'($urandom_range(0, 3));
					end
				end else begin
					noise = {$urandom, $urandom, $urandom, $urandom};
					bases = noise[PROBE_W-1:0];
				end
				send_probe(bases[LOW_W-1:0], bases[PROBE_W-1:LOW_W], st, 1'b0, '0, 1'b0);
				if ($urandom_range(0, 39) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			err_count++;
		end
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
